/* rtl/tld_pkg.sv */
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types and character codes for the terminal line editor: item
// structs, result kinds and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tld_pkg;

    // Character codes
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;

    // Operation codes
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_INTR = 2'd3;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic [6:0] read_len;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [5:0] count;
        logic       ready_res;
        logic       last;
    } t_out_item;

    // Which result the datapath builds on a push
    typedef enum logic [2:0] {
        SEL_BS,
        SEL_SP,
        SEL_CR,
        SEL_CHAR,
        SEL_DATA,
        SEL_DONE_NR,
        SEL_DONE,
        SEL_INTR
    } t_sel;

    typedef struct packed {
        logic load;        // latch the accepted item
        logic apply_char;  // store the byte if room, flag line on LF
        logic erase;       // drop the last stored byte
        logic load_cnt;    // capture min(read_len, fill)
        logic clear_line;  // discard the line after a read
        logic push;        // load a result into the output register
        t_sel sel;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic is_eot;
        logic is_erase;
        logic is_lf;
        logic fill_zero;
        logic line_ready;
        logic min_zero;
        logic idx_at_end;
        logic slot_free;
    } t_stat;

endpackage

/* rtl/tld_dp.sv */
// ----------------------------------------------------------------------------
// tld_dp
// Datapath of the line editor: item latch, line store, fill count, line
// ready flag, read index and the output register.
// ----------------------------------------------------------------------------
module tld_dp #(
    parameter int LINE_LEN = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tld_pkg::t_in_item  i_item,
    input  tld_pkg::t_cmd      i_cmd,
    input  logic               i_out_ready,
    output tld_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output tld_pkg::t_out_item o_out_item
);
    import tld_pkg::*;

    localparam int FW = $clog2(LINE_LEN);
    localparam logic [FW-1:0] FILL_MAX = FW'(LINE_LEN - 1);

    logic            r_op;
    logic [7:0]      r_char;
    logic [6:0]      r_len;
    logic [FW-1:0]   r_fill;
    logic            r_line_ready;
    logic [FW-1:0]   r_cnt;
    logic [FW-1:0]   r_idx;
    logic [FW-1:0]   n_idx;
    logic [7:0]      r_mem [LINE_LEN];
    logic [7:0]      r_rd_data;
    logic            r_out_valid;
    t_out_item       r_out;
    t_out_item       n_res;
    logic [FW-1:0]   min_len;
    logic            room;
    logic [7:0]      rx_mapped;

    // Turn CR into LF on the way in
    assign rx_mapped = (i_item.rx_byte == CH_CR) ? CH_LF : i_item.rx_byte;

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_item.op;
            r_char <= rx_mapped;
            r_len  <= i_item.read_len;
        end
    end

    assign room    = (r_fill < FILL_MAX);
    assign min_len = (r_len < 7'(r_fill)) ? FW'(r_len) : r_fill;

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_line_ready <= 1'b0;
        end else if (i_cmd.clear_line) begin
            r_fill       <= '0;
            r_line_ready <= 1'b0;
        end else if (i_cmd.erase) begin
            r_fill <= r_fill - 1'b1;
        end else if (i_cmd.apply_char) begin
            if (room) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_char == CH_LF) begin
                r_line_ready <= 1'b1;
            end
        end
    end

    // Hold the delivery count for a read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cnt) begin
            r_cnt <= min_len;
        end
    end

    // Read index; the store is read at the next index so data is ready in time
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.load) begin
            n_idx = '0;
        end else if (i_cmd.push && i_cmd.sel == SEL_DATA) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply_char && room) begin
            r_mem[r_fill] <= r_char;
        end
        r_rd_data <= r_mem[n_idx];
    end

    // Build the result selected by the controller
    always_comb begin
        n_res = '0;
        case (i_cmd.sel)
            SEL_BS: begin
                n_res.kind     = KIND_ECHO;
                n_res.out_byte = CH_BS;
            end
            SEL_SP: begin
                n_res.kind     = KIND_ECHO;
                n_res.out_byte = CH_SP;
            end
            SEL_CR: begin
                n_res.kind     = KIND_ECHO;
                n_res.out_byte = CH_CR;
            end
            SEL_CHAR: begin
                n_res.kind     = KIND_ECHO;
                n_res.out_byte = r_char;
            end
            SEL_DATA: begin
                n_res.kind     = KIND_DATA;
                n_res.out_byte = r_rd_data;
            end
            SEL_DONE_NR: begin
                n_res.kind = KIND_DONE;
            end
            SEL_DONE: begin
                n_res.kind      = KIND_DONE;
                n_res.count     = 6'(r_cnt);
                n_res.ready_res = 1'b1;
            end
            SEL_INTR: begin
                n_res.kind = KIND_INTR;
            end
            default: begin
                n_res = '0;
            end
        endcase
        n_res.last = i_cmd.last;
    end

    // Output register: load on push, release on the taking beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Status back to the controller
    always_comb begin
        o_stat.op         = r_op;
        o_stat.is_eot     = (r_char == CH_EOT);
        o_stat.is_erase   = (r_char == CH_DEL) || (r_char == CH_BS);
        o_stat.is_lf      = (r_char == CH_LF);
        o_stat.fill_zero  = (r_fill == '0);
        o_stat.line_ready = r_line_ready;
        o_stat.min_zero   = (min_len == '0);
        o_stat.idx_at_end = ((FW+1)'(r_idx) + 1'b1) == (FW+1)'(r_cnt);
        o_stat.slot_free  = !r_out_valid || i_out_ready;
    end

endmodule

/* rtl/tld_ctrl.sv */
// ----------------------------------------------------------------------------
// tld_ctrl
// Controller of the line editor: decodes the latched item and steps through
// its results, one push per free output slot.
// ----------------------------------------------------------------------------
module tld_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  tld_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output tld_pkg::t_cmd  o_cmd
);
    import tld_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INTR,
        S_BS1,
        S_SP,
        S_BS2,
        S_CR,
        S_ECHO,
        S_DATA,
        S_DONE_NR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel = SEL_CHAR;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op == OP_READ) begin
                    if (!i_stat.line_ready) begin
                        n_state = S_DONE_NR;
                    end else begin
                        o_cmd.load_cnt = 1'b1;
                        n_state = i_stat.min_zero ? S_DONE : S_DATA;
                    end
                end else if (i_stat.is_eot) begin
                    n_state = S_INTR;
                end else if (i_stat.is_erase) begin
                    if (i_stat.fill_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.erase = 1'b1;
                        n_state     = S_BS1;
                    end
                end else begin
                    o_cmd.apply_char = 1'b1;
                    n_state = i_stat.is_lf ? S_CR : S_ECHO;
                end
            end
            S_INTR: begin
                o_cmd.sel  = SEL_INTR;
                o_cmd.last = 1'b1;
                if (i_stat.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_BS1: begin
                o_cmd.sel = SEL_BS;
                if (i_stat.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_SP;
                end
            end
            S_SP: begin
                o_cmd.sel = SEL_SP;
                if (i_stat.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_BS2;
                end
            end
            S_BS2: begin
                o_cmd.sel  = SEL_BS;
                o_cmd.last = 1'b1;
                if (i_stat.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_CR: begin
                o_cmd.sel = SEL_CR;
                if (i_stat.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_ECHO;
                end
            end
            S_ECHO: begin
                o_cmd.sel  = SEL_CHAR;
                o_cmd.last = 1'b1;
                if (i_stat.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DATA: begin
                o_cmd.sel = SEL_DATA;
                if (i_stat.slot_free) begin
                    o_cmd.push = 1'b1;
                    if (i_stat.idx_at_end) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE_NR: begin
                o_cmd.sel  = SEL_DONE_NR;
                o_cmd.last = 1'b1;
                if (i_stat.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DONE: begin
                o_cmd.sel  = SEL_DONE;
                o_cmd.last = 1'b1;
                if (i_stat.slot_free) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.clear_line = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/tty_line_discipline_core.sv */
// ----------------------------------------------------------------------------
// tty_line_discipline_core
// Canonical line editor for a serial terminal port.
// ----------------------------------------------------------------------------
// Each beat on the input is either a received byte or a read request. A byte
// is accepted, decoded and then gives its results in turn: an echo for a plain
// byte, an interrupt result, CR and the LF echo for a line end, BS, SP, BS for
// an erase and none for an erase on an empty line. The line store is read at
// the next index each cycle, so data bytes of a read leave one per cycle while
// the output is not stalled. The single output register sets the pace: every
// result needs a free output slot, so output stalls hold results back. The
// next item is accepted while the final result still waits in the output
// register. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module tty_line_discipline_core #(
    parameter int LINE_LEN = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tld_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tld_pkg::t_out_item o_out_item
);
    import tld_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    tld_dp #(
        .LINE_LEN (LINE_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

/* rtl/tld_checker.sv */
// ----------------------------------------------------------------------------
// tld_checker
// Port-level checks on the line editor's result stream, bound to the top.
// ----------------------------------------------------------------------------
module tld_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input tld_pkg::t_out_item i_out_item
);
    import tld_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result beat changed while stalled");

    // A done marker always closes its item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.kind == KIND_DONE |-> i_out_item.last)
        else $error("done marker without last");

    // An interrupt stands alone with empty payload
    a_intr_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.kind == KIND_INTR |->
            i_out_item.last && i_out_item.out_byte == 8'h00
            && i_out_item.count == 6'd0 && !i_out_item.ready_res)
        else $error("malformed interrupt result");

    // Only a done marker carries a count or a ready flag
    a_count_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.kind != KIND_DONE |->
            i_out_item.count == 6'd0 && !i_out_item.ready_res)
        else $error("count or ready flag outside done marker");

endmodule

bind tty_line_discipline_core tld_checker u_tld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);
